/* rtl/core/d2i_pkg.sv */
package d2i_pkg;

  typedef enum logic [3:0] {
    ACT_SAT   = 4'd0,
    ACT_UINT  = 4'd1,
    ACT_INT   = 4'd2,
    ACT_UMUL  = 4'd3,
    ACT_SAR   = 4'd4,
    ACT_SHR   = 4'd5,
    ACT_AND   = 4'd6,
    ACT_OR    = 4'd7,
    ACT_XOR   = 4'd8,
    ACT_NOT   = 4'd9
  } action_t;

  localparam logic [10:0] EXP_ALL  = 11'h7FF;
  localparam logic [10:0] EXP_BIAS = 11'd1023;
  localparam logic [31:0] SIGN_WORD = 32'h8000_0000;
  localparam logic [31:0] MAX_POS   = 32'h7FFF_FFFF;

  // Stage-one result of one operand conversion
  typedef struct packed {
    logic [31:0] mag;
    logic        neg;
    logic        zero;
    logic        nan;
    logic        big;
  } conv_t;

endpackage

/* rtl/core/d2i_conv.sv */
module d2i_conv (
  input  logic [63:0]      bits,
  output d2i_pkg::conv_t   conv
);

  logic [10:0] ex;
  logic [52:0] mant;
  logic [10:0] scale;
  logic [5:0]  dn;
  logic [4:0]  up;
  logic [84:0] wide;

  // Truncate magnitude and reduce modulo 2^32
  always_comb begin
    ex    = bits[62:52];
    mant  = {1'b1, bits[51:0]};
    scale = ex - d2i_pkg::EXP_BIAS;
    dn    = '0;
    up    = '0;
    wide  = '0;
    conv.mag = '0;
    if (scale >= 11'd52) begin
      up   = scale[4:0] - 5'd20;
      wide = {32'd0, mant} << up;
      if (scale - 11'd52 < 11'd32) conv.mag = wide[31:0];
    end else begin
      dn = 6'd52 - scale[5:0];
      conv.mag = 32'(mant >> dn);
    end
    conv.neg  = bits[63];
    conv.zero = (ex == d2i_pkg::EXP_ALL) || (ex < d2i_pkg::EXP_BIAS);
    conv.nan  = (ex == d2i_pkg::EXP_ALL) && (bits[51:0] != '0);
    conv.big  = ex >= (d2i_pkg::EXP_BIAS + 11'd31);
    if (conv.zero) conv.mag = '0;
  end

endmodule

/* rtl/core/d2i_alu.sv */
module d2i_alu (
  input  logic [3:0]  action,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] prod,
  input  logic [31:0] sat,
  output logic [31:0] word,
  output logic        uns
);

  // Select the operation result
  always_comb begin
    word = '0;
    uns  = 1'b0;
    unique case (action)
      d2i_pkg::ACT_SAT:  word = sat;
      d2i_pkg::ACT_UINT: begin word = a; uns = 1'b1; end
      d2i_pkg::ACT_INT:  word = a;
      d2i_pkg::ACT_UMUL: begin word = prod; uns = 1'b1; end
      d2i_pkg::ACT_SAR:  word = 32'($signed(a) >>> b[4:0]);
      d2i_pkg::ACT_SHR:  begin word = a >> b[4:0]; uns = 1'b1; end
      d2i_pkg::ACT_AND:  word = a & b;
      d2i_pkg::ACT_OR:   word = a | b;
      d2i_pkg::ACT_XOR:  word = a ^ b;
      d2i_pkg::ACT_NOT:  word = ~a;
      default: begin word = '0; uns = 1'b0; end
    endcase
  end

endmodule

/* rtl/core/double_to_int32_bitwise_unit.sv */
// Channel | Signals                                   | Dir
// in      | valid, ready, action, left_bits, right_bits | in
// out     | valid, ready, result_word, result_unsigned  | out
// Three register stages: convert, sign/multiply, select/output.
// One item enters per cycle when out is not stalled.
// The multiplier (32x32 low half) sets the middle stage.
// A stall on out freezes every stage that holds an item; bubbles fill first.
// rst clears the valid bits only and holds in_ready low.
module double_to_int32_bitwise_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  action,
  input  logic [63:0] left_bits,
  input  logic [63:0] right_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] result_word,
  output logic        result_unsigned
);

  d2i_pkg::conv_t cl, cr, s1_l, s1_r;
  logic [3:0]  s1_act, s2_act;
  logic        s1_v, s2_v, s3_v;
  logic [31:0] a_w, b_w, s2_a, s2_b, s2_prod, s2_sat, sat_w, word_w;
  logic        uns_w;
  logic        en1, en2, en3;

  d2i_conv u_cl (.bits(left_bits),  .conv(cl));
  d2i_conv u_cr (.bits(right_bits), .conv(cr));

  // Advance a stage when it is empty or the next one moves
  assign en3      = !s3_v || out_ready;
  assign en2      = !s2_v || en3;
  assign en1      = !s1_v || en2;
  assign in_ready = en1 && !rst;
  assign out_valid = s3_v;

  // Apply sign and saturation
  always_comb begin
    a_w = s1_l.neg ? 32'(-s1_l.mag) : s1_l.mag;
    b_w = s1_r.neg ? 32'(-s1_r.mag) : s1_r.mag;
    if (s1_l.nan) sat_w = '0;
    else if (s1_l.big) sat_w = s1_l.neg ? d2i_pkg::SIGN_WORD : d2i_pkg::MAX_POS;
    else sat_w = a_w;
  end

  d2i_alu u_alu (
    .action(s2_act), .a(s2_a), .b(s2_b), .prod(s2_prod), .sat(s2_sat),
    .word(word_w), .uns(uns_w)
  );

  // Hold valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      if (en1) s1_v <= in_valid;
      if (en2) s2_v <= s1_v;
      if (en3) s3_v <= s2_v;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_l   <= cl;
      s1_r   <= cr;
      s1_act <= action;
    end
    if (en2) begin
      s2_a    <= a_w;
      s2_b    <= b_w;
      s2_sat  <= sat_w;
      s2_act  <= s1_act;
      s2_prod <= 32'(a_w * b_w);
    end
    if (en3) begin
      result_word     <= word_w;
      result_unsigned <= uns_w;
    end
  end

endmodule

/* verif/double_to_int32_bitwise_unit_tb.sv */
`timescale 1ns / 100ps

module double_to_int32_bitwise_unit_tb;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [3:0]  action;
  logic [63:0] left_bits;
  logic [63:0] right_bits;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] result_word;
  logic        result_unsigned;

  typedef struct {
    logic [31:0] word;
    logic        uns;
  } int_result_t;

  int_result_t pending_results[$];
  int          error_count;
  int          send_idle_pct;
  int          recv_stall_pct;

  double_to_int32_bitwise_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .left_bits(left_bits), .right_bits(right_bits),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_word(result_word), .result_unsigned(result_unsigned)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Truncate toward zero and wrap modulo 2^32; NaN, infinity and |x| < 1 give 0
  function automatic logic [31:0] wrap_to_u32(logic [63:0] bits);
    logic [10:0] ex;
    logic [52:0] mant;
    logic [95:0] wide;
    logic [31:0] mag;
    int          scale;
    ex = bits[62:52];
    if (ex == d2i_pkg::EXP_ALL || ex < d2i_pkg::EXP_BIAS) return 32'd0;
    mant = {1'b1, bits[51:0]};
    scale = int'(ex) - 1023;
    if (scale >= 52) begin
      if (scale - 52 >= 32) return 32'd0;
      wide = {43'd0, mant} << (scale - 52);
      mag = wide[31:0];
    end else begin
      wide = {43'd0, mant} >> (52 - scale);
      mag = wide[31:0];
    end
    return bits[63] ? 32'd0 - mag : mag;
  endfunction

  function automatic logic [31:0] clamp_to_i32(logic [63:0] bits);
    logic [10:0] ex;
    ex = bits[62:52];
    if (ex == d2i_pkg::EXP_ALL && bits[51:0] != 52'd0) return 32'd0;
    if (ex >= 11'd1054) return bits[63] ? d2i_pkg::SIGN_WORD : d2i_pkg::MAX_POS;
    return wrap_to_u32(bits);
  endfunction

  function automatic int_result_t compute_result(logic [3:0] act, logic [63:0] lb,
                                                 logic [63:0] rb);
    int_result_t r;
    logic [31:0] a;
    logic [31:0] b;
    logic [63:0] prod;
    a = wrap_to_u32(lb);
    b = wrap_to_u32(rb);
    r.word = 32'd0;
    r.uns = 1'b0;
    case (act)
      d2i_pkg::ACT_SAT:  r.word = clamp_to_i32(lb);
      d2i_pkg::ACT_UINT: begin r.word = a; r.uns = 1'b1; end
      d2i_pkg::ACT_INT:  r.word = a;
      d2i_pkg::ACT_UMUL: begin
        prod = a * b;
        r.word = prod[31:0];
        r.uns = 1'b1;
      end
      d2i_pkg::ACT_SAR:  r.word = $signed(a) >>> b[4:0];
      d2i_pkg::ACT_SHR:  begin r.word = a >> b[4:0]; r.uns = 1'b1; end
      d2i_pkg::ACT_AND:  r.word = a & b;
      d2i_pkg::ACT_OR:   r.word = a | b;
      d2i_pkg::ACT_XOR:  r.word = a ^ b;
      d2i_pkg::ACT_NOT:  r.word = ~a;
      default:  ;
    endcase
    return r;
  endfunction

  // Send one item, holding it until accepted
  task automatic send_item(logic [3:0] act, logic [63:0] lb, logic [63:0] rb);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    left_bits <= lb;
    right_bits <= rb;
    pending_results.push_back(compute_result(act, lb, rb));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Randomize receiver stall each cycle
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    int_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result_word unexpected: actual %h", result_word);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (result_word !== exp_r.word) begin
          $error("result_word expected %h actual %h", exp_r.word, result_word);
          error_count++;
        end
        if (result_unsigned !== exp_r.uns) begin
          $error("result_unsigned expected %b actual %b", exp_r.uns, result_unsigned);
          error_count++;
        end
      end
    end
  end

  function automatic logic [63:0] make_double(logic s, int unsigned ex, logic [51:0] fr);
    return {s, ex[10:0], fr};
  endfunction

  // Random operand biased toward the interesting exponent window
  function automatic logic [63:0] rand_operand();
    logic [51:0] fr;
    int unsigned sel;
    fr = 52'({$urandom, $urandom});
    sel = $urandom_range(9, 0);
    if (sel < 6)
      return make_double(1'($urandom_range(1, 0)), $urandom_range(1120, 1015), fr);
    if (sel == 6)
      return make_double(1'($urandom_range(1, 0)), 2047,
                         $urandom_range(1, 0) ? fr : 52'd0);
    if (sel == 7)
      return make_double(1'($urandom_range(1, 0)), $urandom_range(1, 0) ? 0 : 1023,
                         52'd0);
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed();
    logic [63:0] vals[12];
    vals[0] = 64'h0;                          // +0
    vals[1] = 64'h8000_0000_0000_0000;        // -0
    vals[2] = 64'h7FF0_0000_0000_0000;        // +inf
    vals[3] = 64'hFFF0_0000_0000_0000;        // -inf
    vals[4] = 64'h7FF8_0000_0000_0001;        // NaN
    vals[5] = 64'h41DF_FFFF_FFC0_0000;        // 2147483647
    vals[6] = 64'hC1E0_0000_0000_0000;        // -2147483648
    vals[7] = 64'h41F0_0000_0000_0000;        // 2^32 wraps to zero
    vals[8] = 64'h3FEF_FFFF_FFFF_FFFF;        // just below one
    vals[9] = 64'hC00C_0000_0000_0000;        // -3.5
    vals[10] = 64'hFFEF_FFFF_FFFF_FFFF;       // largest finite negative
    vals[11] = 64'h4340_0000_0000_0001;       // beyond mantissa, up shift
    for (int i = 0; i < 12; i++) send_item(d2i_pkg::ACT_SAT, vals[i], vals[11 - i]);
    for (int k = 1; k < 16; k++) send_item(k[3:0], vals[k % 12], vals[(k + 5) % 12]);
    // shift 31
    send_item(d2i_pkg::ACT_SHR, 64'hC1E0_0000_0000_0000, 64'h403F_0000_0000_0000);
    go_idle();
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++)
      send_item(4'($urandom_range(15, 0)), rand_operand(), rand_operand());
    go_idle();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    action = '0;
    left_bits = '0;
    right_bits = '0;
    error_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(340);
    send_idle_pct = 49;
    test_random(330);
    send_idle_pct = 0;
    recv_stall_pct = 49;
    test_random(330);
    send_idle_pct = 17;
    recv_stall_pct = 17;
    test_random(330);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
